FILE: sv/jhtb_pkg.sv
`default_nettype none

package jhtb_pkg;

	localparam int NUM_TABLES  = 4;
	localparam int TBL_W       = 2;
	localparam int NUM_LENGTHS = 16;

	localparam logic [7:0] CLS_DC0 = 8'h00;
	localparam logic [7:0] CLS_DC1 = 8'h01;
	localparam logic [7:0] CLS_AC0 = 8'h10;
	localparam logic [7:0] CLS_AC1 = 8'h11;

	localparam logic [3:0] LAST_CPOS  = 4'd15;
	localparam logic [4:0] MAX_LENGTH = 5'd16;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COUNTS  = 2'd1,
		PH_SYMBOLS = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_STORED    = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_BAD_CLASS = 2'd2,
		ST_DROPPED   = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [1:0]  table_id;
		logic [7:0]  entry_index;
		logic [7:0]  symbol_value;
		logic [15:0] code_bits;
		logic [4:0]  code_length;
		logic        last;
		logic [8:0]  table_size;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/jhtb_in_if.sv
`default_nettype none

interface jhtb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       seg_start;

	modport source (output valid, output data_byte, output seg_start, input ready);
	modport sink (input valid, input data_byte, input seg_start, output ready);
endinterface

`default_nettype wire

FILE: sv/jhtb_out_if.sv
`default_nettype none

interface jhtb_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [1:0]  table_id;
	logic [7:0]  entry_index;
	logic [7:0]  symbol_value;
	logic [15:0] code_bits;
	logic [4:0]  code_length;
	logic        last;
	logic [8:0]  table_size;

	modport source (
		output valid, output status, output table_id, output entry_index,
		output symbol_value, output code_bits, output code_length, output last,
		output table_size, input ready
	);
	modport sink (
		input valid, input status, input table_id, input entry_index,
		input symbol_value, input code_bits, input code_length, input last,
		input table_size, output ready
	);
endinterface

`default_nettype wire

FILE: sv/jhtb_ram.sv
`default_nettype none

module jhtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

FILE: sv/jhtb_codegen.sv
`default_nettype none

module jhtb_codegen #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     data_byte,
	input  logic           seg_start,
	output logic           res_valid,
	output jhtb_pkg::res_t res
);
	import jhtb_pkg::*;

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int SW = TBL_W + AW;
	localparam logic [8:0] MAX_SIZE = 9'(MAX_ENTRIES);

	phase_t      phase_q, phase_d;
	logic [1:0]  tbl_q;
	logic [3:0]  cpos_q;
	logic [11:0] expect_q;
	logic [11:0] seen_q;
	logic [15:0] code_q;
	logic [4:0]  len_q;
	logic [7:0]  left_q;
	logic        pend_q;
	logic [15:0] nz_q;
	logic [8:0]  size_q;

	logic        cls_ok;
	logic [1:0]  cls_tid;
	logic [7:0]  len_rdata;
	logic [7:0]  left_cur, left_dec;
	logic [15:0] code_inc, code_adv;
	logic [11:0] seen_inc, expect_sum;
	logic        last_sym, cnt_end, overflow, adv;
	logic [15:0] srch_mask;
	logic [4:0]  srch_lo;
	logic        found;
	logic [3:0]  idx;
	logic [4:0]  len_new;
	logic [3:0]  shift_amt;
	logic        in_counts, in_symbols;
	logic        len_we, len_re;
	logic        sto_we;
	logic [SW-1:0] sto_addr;

	// class byte decoder
	always_comb begin
		cls_ok  = 1'b0;
		cls_tid = 2'd0;
		unique case (data_byte)
			CLS_DC0: begin
				cls_ok  = 1'b1;
				cls_tid = 2'd0;
			end
			CLS_DC1: begin
				cls_ok  = 1'b1;
				cls_tid = 2'd1;
			end
			CLS_AC0: begin
				cls_ok  = 1'b1;
				cls_tid = 2'd2;
			end
			CLS_AC1: begin
				cls_ok  = 1'b1;
				cls_tid = 2'd3;
			end
			default: begin
				cls_ok  = 1'b0;
				cls_tid = 2'd0;
			end
		endcase
	end

	assign in_counts  = take && !seg_start && (phase_q == PH_COUNTS);
	assign in_symbols = take && !seg_start && (phase_q == PH_SYMBOLS);

	// count of the current length, straight from the ram after a fresh read
	assign left_cur   = pend_q ? len_rdata : left_q;
	assign left_dec   = (left_cur != 8'd0) ? left_cur - 8'd1 : 8'd0;
	assign code_inc   = code_q + 16'd1;
	assign seen_inc   = seen_q + 12'd1;
	assign expect_sum = expect_q + {4'd0, data_byte};
	assign last_sym   = (seen_inc == expect_q);
	assign cnt_end    = (cpos_q == LAST_CPOS);
	assign overflow   = (size_q >= MAX_SIZE);
	assign adv        = (left_dec == 8'd0) && (len_q < MAX_LENGTH);

	// next non-empty length
	assign srch_mask = (phase_q == PH_COUNTS) ? {data_byte != 8'd0, nz_q[14:0]} : nz_q;
	assign srch_lo   = (phase_q == PH_COUNTS) ? 5'd0 : len_q;

	always_comb begin
		found = 1'b0;
		idx   = 4'd15;
		for (int j = NUM_LENGTHS - 1; j >= 0; j--) begin
			if (srch_mask[j] && (5'(j) >= srch_lo)) begin
				found = 1'b1;
				idx   = 4'(j);
			end
		end
	end

	assign len_new   = found ? ({1'b0, idx} + 5'd1) : MAX_LENGTH;
	assign shift_amt = 4'(len_new - len_q);
	assign code_adv  = code_inc << shift_amt;

	assign len_we = in_counts;
	assign len_re = (in_counts && cnt_end && (expect_sum != 12'd0) && (idx != LAST_CPOS))
		|| (in_symbols && !last_sym && adv && found);

	assign sto_we   = in_symbols && !overflow;
	assign sto_addr = {tbl_q, size_q[AW-1:0]};

	jhtb_ram #(
		.WIDTH (8),
		.DEPTH (NUM_LENGTHS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (cpos_q),
		.wdata (data_byte),
		.re    (len_re),
		.raddr (idx),
		.rdata (len_rdata)
	);

	// symbol and code of every entry, all four tables
	jhtb_ram #(
		.WIDTH (24),
		.DEPTH (NUM_TABLES * MAX_ENTRIES)
	) u_sto_ram (
		.clk   (clk),
		.we    (sto_we),
		.waddr (sto_addr),
		.wdata ({data_byte, code_q}),
		.re    (1'b0),
		.raddr (sto_addr),
		.rdata ()
	);

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			if (seg_start) begin
				phase_d = cls_ok ? PH_COUNTS : PH_IDLE;
			end else begin
				unique case (phase_q)
					PH_COUNTS: begin
						if (cnt_end) begin
							phase_d = (expect_sum == 12'd0) ? PH_IDLE : PH_SYMBOLS;
						end
					end
					PH_SYMBOLS: begin
						if (last_sym) begin
							phase_d = PH_IDLE;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// result record
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (take && seg_start && !cls_ok) begin
			res_valid   = 1'b1;
			res.status  = ST_BAD_CLASS;
			res.last    = 1'b1;
		end else if (in_counts && cnt_end && (expect_sum == 12'd0)) begin
			res_valid    = 1'b1;
			res.status   = ST_EMPTY;
			res.table_id = tbl_q;
			res.last     = 1'b1;
		end else if (in_symbols) begin
			res_valid        = 1'b1;
			res.table_id     = tbl_q;
			res.symbol_value = data_byte;
			res.last         = last_sym;
			if (!overflow) begin
				res.status      = ST_STORED;
				res.entry_index = 8'(size_q);
				res.code_bits   = code_q;
				res.code_length = len_q;
				res.table_size  = size_q + 9'd1;
			end else begin
				res.status     = ST_DROPPED;
				res.table_size = size_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tbl_q    <= 2'd0;
			cpos_q   <= 4'd0;
			expect_q <= 12'd0;
			seen_q   <= 12'd0;
			code_q   <= 16'd0;
			len_q    <= 5'd0;
			left_q   <= 8'd0;
			pend_q   <= 1'b0;
			nz_q     <= 16'd0;
			size_q   <= 9'd0;
		end else begin
			phase_q <= phase_d;
			if (take) begin
				if (seg_start) begin
					pend_q <= 1'b0;
					if (cls_ok) begin
						tbl_q    <= cls_tid;
						cpos_q   <= 4'd0;
						expect_q <= 12'd0;
						seen_q   <= 12'd0;
						code_q   <= 16'd0;
						len_q    <= 5'd0;
						left_q   <= 8'd0;
						size_q   <= 9'd0;
					end
				end else if (phase_q == PH_COUNTS) begin
					nz_q[cpos_q] <= (data_byte != 8'd0);
					expect_q     <= expect_sum;
					if (!cnt_end) begin
						cpos_q <= cpos_q + 4'd1;
					end else if (expect_sum != 12'd0) begin
						code_q <= 16'd0;
						len_q  <= len_new;
						if (idx == LAST_CPOS) begin
							left_q <= data_byte;
							pend_q <= 1'b0;
						end else begin
							pend_q <= 1'b1;
						end
					end
				end else if (phase_q == PH_SYMBOLS) begin
					seen_q <= seen_inc;
					if (!overflow) begin
						size_q <= size_q + 9'd1;
					end
					if (!last_sym && adv) begin
						code_q <= code_adv;
						len_q  <= len_new;
						if (found) begin
							pend_q <= 1'b1;
						end else begin
							left_q <= 8'd0;
							pend_q <= 1'b0;
						end
					end else begin
						code_q <= code_inc;
						left_q <= left_dec;
						pend_q <= 1'b0;
					end
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pend_symbols: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (phase_q == PH_SYMBOLS))
		else $error("count read pending outside symbol phase");

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= MAX_SIZE)
		else $error("table size beyond capacity");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SYMBOLS) |-> ((len_q != 5'd0) && (len_q <= MAX_LENGTH)))
		else $error("code length out of range in symbol phase");

	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> take)
		else $error("result without an accepted item");
`endif
endmodule

`default_nettype wire

FILE: sv/jhtb_outq.sv
`default_nettype none

module jhtb_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  jhtb_pkg::res_t push_data,
	output logic           can_take,
	output logic           out_valid,
	input  logic           out_ready,
	output jhtb_pkg::res_t out_data
);
	import jhtb_pkg::*;

	logic out_v_q;
	logic skid_v_q;
	res_t main_q;
	res_t skid_q;
	logic pop;

	assign pop       = out_v_q && out_ready;
	assign can_take  = !skid_v_q;
	assign out_valid = out_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || pop) begin
				if (skid_v_q) begin
					out_v_q  <= 1'b1;
					skid_v_q <= 1'b0;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || pop) begin
			main_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid item held with empty output register");
`endif
endmodule

`default_nettype wire

FILE: sv/jpeg_huffman_table_builder.sv
// channel  dir  fields
// in_ch    in   data_byte[7:0] seg_start
// out_ch   out  status[1:0] table_id[1:0] entry_index[7:0] symbol_value[7:0]
//               code_bits[15:0] code_length[4:0] last table_size[8:0]
//
// one item per cycle while in_ch.ready is high; each result leaves a register
// the count of the next code length comes from a registered ram read, forwarded
// into the following symbol
// a two-entry output queue takes one more result while the output stalls
// arst_n clears all control state; ram contents are undefined after reset
`default_nettype none

module jpeg_huffman_table_builder #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	jhtb_in_if.sink           in_ch,
	jhtb_out_if.source        out_ch
);
	import jhtb_pkg::*;

	logic take;
	logic can_take;
	logic res_valid;
	res_t res;
	res_t out_data;

	assign in_ch.ready = can_take;
	assign take        = in_ch.valid && can_take;

	jhtb_codegen #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_codegen (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (in_ch.data_byte),
		.seg_start (in_ch.seg_start),
		.res_valid (res_valid),
		.res       (res)
	);

	jhtb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.can_take  (can_take),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_data  (out_data)
	);

	assign out_ch.status       = out_data.status;
	assign out_ch.table_id     = out_data.table_id;
	assign out_ch.entry_index  = out_data.entry_index;
	assign out_ch.symbol_value = out_data.symbol_value;
	assign out_ch.code_bits    = out_data.code_bits;
	assign out_ch.code_length  = out_data.code_length;
	assign out_ch.last         = out_data.last;
	assign out_ch.table_size   = out_data.table_size;
endmodule

`default_nettype wire
